[sv/motor_speed_command_parser_unit_defines.svh]
`ifndef MOTOR_SPEED_COMMAND_PARSER_UNIT_DEFINES_SVH
`define MOTOR_SPEED_COMMAND_PARSER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define MSC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define MSC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define MSC_ASSERT(lbl, prop)
`define MSC_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

[sv/msc_pkg.sv]
package msc_pkg;

  localparam int MOTORS  = 4;
  localparam int MOTOR_W = 2;

  localparam logic       OP_BYTE = 1'b0;
  localparam logic       OP_TICK = 1'b1;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;

  localparam logic [6:0] SPEED_MAX = 7'd100;
  localparam logic [2:0] TOKENS    = 3'd5;

  localparam logic [2:0] REG_CLK    = 3'd0;
  localparam logic [2:0] REG_RATE   = 3'd1;
  localparam logic [2:0] REG_WD     = 3'd2;
  localparam logic [2:0] REG_INV    = 3'd3;
  localparam logic [2:0] REG_NARROW = 3'd4;

  typedef enum logic [2:0] {
    PH_GAP, PH_HEAD, PH_LEAD, PH_SIGN, PH_DIGIT
  } phase_e;

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_DIV, S_SRCH, S_OUT
  } state_e;

  typedef struct packed {
    logic [31:0] clk_hz;
    logic [15:0] rate;
    logic [15:0] wd_ticks;
    logic [3:0]  invert;
    logic [3:0]  narrow;
  } cfg_t;

  typedef struct packed {
    logic take;
    logic prep;
    logic div_step;
    logic srch_step;
    logic load_res;
    logic next_motor;
  } cmd_t;

  typedef struct packed {
    logic tick;
    logic fire;
    logic line_ok;
    logic wd_mode;
    logic speed_zero;
    logic div_done;
    logic srch_done;
    logic last_motor;
  } sts_t;

  typedef struct packed {
    logic [1:0]  motor_index;
    logic        running;
    logic        direction_level;
    logic [15:0] prescaler_code;
    logic [31:0] reload_value;
    logic        cause;
    logic        last;
  } res_t;

endpackage

[sv/msc_if.sv]
interface msc_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] rx_byte;
  modport source (output valid, operation, rx_byte, input ready);
  modport sink (input valid, operation, rx_byte, output ready);
endinterface

interface msc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  motor_index;
  logic        running;
  logic        direction_level;
  logic [15:0] prescaler_code;
  logic [31:0] reload_value;
  logic        cause;
  logic        last;
  modport source (output valid, motor_index, running, direction_level, prescaler_code,
                  reload_value, cause, last, input ready);
  modport sink (input valid, motor_index, running, direction_level, prescaler_code,
                reload_value, cause, last, output ready);
endinterface

[sv/msc_ctrl.sv]
module msc_ctrl
  import msc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && ((sts_i.tick && sts_i.fire) || (!sts_i.tick && sts_i.line_ok))) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        if (sts_i.wd_mode || sts_i.speed_zero) begin
          state_d = S_OUT;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        if (sts_i.srch_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = sts_i.last_motor ? S_IDLE : S_PREP;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.take  = in_valid_i;
      end
      S_PREP: begin
        cmd_o.prep     = 1'b1;
        cmd_o.load_res = sts_i.wd_mode || sts_i.speed_zero;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      S_SRCH: begin
        cmd_o.srch_step = 1'b1;
        cmd_o.load_res  = sts_i.srch_done;
      end
      S_OUT: begin
        out_valid_o      = 1'b1;
        cmd_o.next_motor = out_ready_i;
      end
      default: ;
    endcase
  end

endmodule

[sv/msc_datapath.sv]
module msc_datapath
  import msc_pkg::*;
#(
  parameter int LINE_BYTES = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  cmd_t       cmd_i,
  input  logic       op_i,
  input  logic [7:0] byte_i,
  output sts_t       sts_o,
  output res_t       res_o
);

  localparam int LEN_W = $clog2(LINE_BYTES);

  logic [LEN_W-1:0] len_q, len_d;
  logic [2:0]       tok_q, tok_d;
  phase_e           ph_q, ph_d;
  logic [6:0]       acc_q, acc_d;
  logic             neg_q, neg_d;
  logic             rej_q, rej_d;
  logic [7:0]       spd_q [MOTORS];
  logic [15:0]      idle_q;
  logic             stopped_q;

  logic             line_ok;
  logic             wr_en;
  logic [1:0]       wr_slot;
  logic [7:0]       wr_val;
  logic             is_digit, is_blank, is_sign, lead_like;
  logic [6:0]       acc_base;
  logic [9:0]       acc_next;
  logic [6:0]       acc_sat;
  logic             end_rej;
  logic             fire;

  logic [MOTOR_W-1:0] mot_q;
  logic               cause_q;
  logic [22:0]        freq_q;
  logic [22:0]        rem_q;
  logic [31:0]        quo_q;
  logic [4:0]         cnt_q;
  logic [3:0]         k_q;
  res_t               res_q;

  logic [7:0]  cur_spd;
  logic [6:0]  mag;
  logic        spd_neg;
  logic        spd_zero;
  logic [15:0] rate_eff;
  logic [23:0] trial_in;
  logic [24:0] trial;
  logic [31:0] cand;
  logic [31:0] arr;
  logic        narrow;
  logic        fits;

  assign is_digit  = (byte_i >= CH_0) && (byte_i <= CH_9);
  assign is_blank  = (byte_i == CH_TAB) || (byte_i == CH_VT) || (byte_i == CH_FF);
  assign is_sign   = (byte_i == CH_PLUS) || (byte_i == CH_MINUS);
  assign lead_like = (ph_q == PH_GAP) || (ph_q == PH_LEAD);
  assign acc_base  = (ph_q == PH_GAP) ? 7'd0 : acc_q;
  assign acc_next  = 10'({3'b0, acc_base} * 10'd10) + {6'b0, byte_i[3:0]};
  assign acc_sat   = (acc_next > {3'b0, SPEED_MAX}) ? SPEED_MAX : acc_next[6:0];

  assign wr_en   = (ph_q == PH_DIGIT) && (tok_q >= 3'd2) && (tok_q <= TOKENS);
  assign wr_slot = 2'(tok_q - 3'd2);
  assign wr_val  = neg_q ? 8'(-{1'b0, acc_q}) : {1'b0, acc_q};
  assign end_rej = rej_q || (ph_q == PH_LEAD) || (ph_q == PH_SIGN);

  always_comb begin
    len_d   = len_q;
    tok_d   = tok_q;
    ph_d    = ph_q;
    acc_d   = acc_q;
    neg_d   = neg_q;
    rej_d   = rej_q;
    line_ok = 1'b0;
    if (byte_i == CH_CR) begin
      len_d = len_q;
    end else if (byte_i == CH_LF) begin
      line_ok = !end_rej && (tok_q == TOKENS);
      len_d = '0;
      tok_d = '0;
      ph_d  = PH_GAP;
      acc_d = '0;
      neg_d = 1'b0;
      rej_d = 1'b0;
    end else if (len_q < LEN_W'(LINE_BYTES - 1)) begin
      len_d = len_q + 1'b1;
      if (byte_i == CH_SP) begin
        rej_d = end_rej;
        ph_d  = PH_GAP;
      end else if (!rej_q) begin
        if (ph_q == PH_HEAD) begin
          rej_d = 1'b1;
        end else if (ph_q == PH_GAP && tok_q >= TOKENS) begin
          rej_d = 1'b1;
        end else if (ph_q == PH_GAP && tok_q == 3'd0) begin
          tok_d = 3'd1;
          if (byte_i == CH_M) begin
            ph_d = PH_HEAD;
          end else begin
            rej_d = 1'b1;
          end
        end else begin
          if (ph_q == PH_GAP) begin
            tok_d = tok_q + 3'd1;
            acc_d = '0;
            neg_d = 1'b0;
            ph_d  = PH_LEAD;
          end
          if (is_digit) begin
            acc_d = acc_sat;
            ph_d  = PH_DIGIT;
          end else if (lead_like && is_blank) begin
            ph_d = PH_LEAD;
          end else if (lead_like && is_sign) begin
            neg_d = (byte_i == CH_MINUS);
            ph_d  = PH_SIGN;
          end else begin
            rej_d = 1'b1;
          end
        end
      end
    end else begin
      len_d = '0;
      tok_d = '0;
      ph_d  = PH_GAP;
      acc_d = '0;
      neg_d = 1'b0;
      rej_d = 1'b0;
    end
  end

  assign fire = !stopped_q && (idle_q >= cfg_i.wd_ticks);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      tok_q     <= '0;
      ph_q      <= PH_GAP;
      acc_q     <= '0;
      neg_q     <= 1'b0;
      rej_q     <= 1'b0;
      idle_q    <= '0;
      stopped_q <= 1'b1;
      for (int i = 0; i < MOTORS; i++) begin
        spd_q[i] <= '0;
      end
    end else if (cmd_i.take) begin
      if (op_i == OP_TICK) begin
        stopped_q <= stopped_q || fire;
        if (idle_q != 16'hFFFF) begin
          idle_q <= idle_q + 16'd1;
        end
      end else begin
        len_q <= len_d;
        tok_q <= tok_d;
        ph_q  <= ph_d;
        acc_q <= acc_d;
        neg_q <= neg_d;
        rej_q <= rej_d;
        if ((byte_i == CH_LF || (byte_i == CH_SP && len_q < LEN_W'(LINE_BYTES - 1)))
            && wr_en) begin
          spd_q[wr_slot] <= wr_val;
        end
        if (line_ok) begin
          idle_q    <= '0;
          stopped_q <= 1'b0;
        end
      end
    end
  end

  assign cur_spd  = spd_q[mot_q];
  assign spd_neg  = cur_spd[7];
  assign mag      = spd_neg ? 7'(-cur_spd) : cur_spd[6:0];
  assign spd_zero = (cur_spd == 8'd0);
  assign rate_eff = (cfg_i.rate == 16'd0) ? 16'd1 : cfg_i.rate;

  assign trial_in = {rem_q, quo_q[31]};
  assign trial    = {1'b0, trial_in} - {2'b0, freq_q};

  assign cand   = quo_q >> ({1'b0, k_q} + 5'd1);
  assign arr    = (cand != 32'd0) ? cand - 32'd1 : 32'd0;
  assign narrow = cfg_i.narrow[mot_q];
  assign fits   = !narrow || (arr[31:16] == 16'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mot_q   <= '0;
      cause_q <= 1'b0;
    end else if (cmd_i.take) begin
      mot_q   <= '0;
      cause_q <= op_i;
    end else if (cmd_i.next_motor) begin
      mot_q <= mot_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      freq_q <= {16'b0, mag} * {7'b0, rate_eff};
      rem_q  <= '0;
      quo_q  <= cfg_i.clk_hz;
      cnt_q  <= '0;
      k_q    <= '0;
    end
    if (cmd_i.div_step) begin
      cnt_q <= cnt_q + 5'd1;
      if (!trial[24]) begin
        rem_q <= trial[22:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= trial_in[22:0];
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
    if (cmd_i.srch_step) begin
      k_q <= k_q + 4'd1;
    end
    if (cmd_i.load_res) begin
      res_q.motor_index     <= mot_q;
      res_q.cause           <= cause_q;
      res_q.last            <= (mot_q == MOTOR_W'(MOTORS - 1));
      res_q.direction_level <= !((spd_neg && !cause_q) ^ cfg_i.invert[mot_q]);
      if (cause_q || spd_zero) begin
        res_q.running        <= 1'b0;
        res_q.prescaler_code <= '0;
        res_q.reload_value   <= '0;
      end else if (fits) begin
        res_q.running        <= 1'b1;
        res_q.prescaler_code <= (16'd1 << k_q) - 16'd1;
        res_q.reload_value   <= arr;
      end else begin
        res_q.running        <= 1'b1;
        res_q.prescaler_code <= 16'hFFFF;
        res_q.reload_value   <= 32'h0000FFFF;
      end
    end
  end

  assign res_o = res_q;

  assign sts_o.tick       = (op_i == OP_TICK);
  assign sts_o.fire       = fire;
  assign sts_o.line_ok    = line_ok;
  assign sts_o.wd_mode    = cause_q;
  assign sts_o.speed_zero = spd_zero;
  assign sts_o.div_done   = (cnt_q == 5'd31);
  assign sts_o.srch_done  = fits || (k_q == 4'd15);
  assign sts_o.last_motor = (mot_q == MOTOR_W'(MOTORS - 1));

endmodule

[sv/motor_speed_command_parser_unit.sv]
// Channel  Direction  Word contents
// in_i     sink       operation (byte or tick), rx_byte
// out_o    source     motor_index, running, direction_level, prescaler_code,
//                     reload_value, cause, last
// apb      slave      timer clock, rate, watchdog, invert mask, narrow mask
//
// A tick that fires the watchdog or a byte that ends a valid command line starts a
// run of four results; no other word does. Each stop result goes from prep to output;
// each running motor of a command line passes the 32-step divider and prescaler search.
// The block accepts no word while a run is in progress or a result is held.
// Reset is asynchronous and active low; no clearing pass is needed.
`include "motor_speed_command_parser_unit_defines.svh"

module motor_speed_command_parser_unit
  import msc_pkg::*;
#(
  parameter int LINE_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  msc_in_if.sink      in_i,
  msc_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;
  res_t res;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clk_hz   <= 32'd4000000;
      cfg_q.rate     <= 16'd50;
      cfg_q.wd_ticks <= 16'd300;
      cfg_q.invert   <= 4'd10;
      cfg_q.narrow   <= 4'd2;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_CLK:    cfg_q.clk_hz   <= pwdata;
        REG_RATE:   cfg_q.rate     <= pwdata[15:0];
        REG_WD:     cfg_q.wd_ticks <= pwdata[15:0];
        REG_INV:    cfg_q.invert   <= pwdata[3:0];
        REG_NARROW: cfg_q.narrow   <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CLK:    prdata = cfg_q.clk_hz;
      REG_RATE:   prdata = {16'd0, cfg_q.rate};
      REG_WD:     prdata = {16'd0, cfg_q.wd_ticks};
      REG_INV:    prdata = {28'd0, cfg_q.invert};
      REG_NARROW: prdata = {28'd0, cfg_q.narrow};
      default:    prdata = '0;
    endcase
  end

  msc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  msc_datapath #(
    .LINE_BYTES(LINE_BYTES)
  ) u_datapath (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_q),
    .cmd_i (cmd),
    .op_i  (in_i.operation),
    .byte_i(in_i.rx_byte),
    .sts_o (sts),
    .res_o (res)
  );

  assign out_o.motor_index     = res.motor_index;
  assign out_o.running         = res.running;
  assign out_o.direction_level = res.direction_level;
  assign out_o.prescaler_code  = res.prescaler_code;
  assign out_o.reload_value    = res.reload_value;
  assign out_o.cause           = res.cause;
  assign out_o.last            = res.last;

  `MSC_ASSERT(a_ready_excl, !(in_i.ready && out_o.valid))
  `MSC_ASSERT_IMP(a_last_frees, out_o.valid && out_o.ready && out_o.last, ##1 in_i.ready)
  `MSC_ASSERT_IMP(a_mid_busy, out_o.valid && out_o.ready && !out_o.last, ##1 !in_i.ready)
  `MSC_ASSERT_IMP(a_stop_idle, out_o.valid && out_o.cause, !out_o.running)

endmodule
